>>> rtl/crip_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crip_pkg
// Shared types and constants of the cursor image rotate and pack block.
// ----------------------------------------------------------------------------
package crip_pkg;

  localparam int CURSOR_SIZE = 32;
  localparam int ROW_W       = 5;
  localparam int DIM_W       = 11;
  localparam int COL_W       = 8;
  localparam int ADDR_W      = 7;
  localparam int WORD_W      = 64;
  localparam int CFG_IDX_W   = 2;

  // Item modes
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_READ = 1'b1;

  // Rotation codes; the unused code behaves as no rotation
  localparam logic [1:0] ROT_NONE = 2'd0;
  localparam logic [1:0] ROT_CW   = 2'd1;
  localparam logic [1:0] ROT_CCW  = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROTATION = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = 2'd2;

  localparam logic [DIM_W-1:0] WIDTH_MAX  = 11'd1024;
  localparam logic [DIM_W-1:0] ROW_SAT    = 11'd2047;
  localparam logic [DIM_W-1:0] WIDTH_RST  = 11'd32;
  localparam logic [DIM_W-1:0] HEIGHT_RST = 11'd32;

  typedef logic [CURSOR_SIZE-1:0][CURSOR_SIZE-1:0] plane_t;

  typedef struct packed {
    logic [1:0]       rotation;
    logic [DIM_W-1:0] source_width;
    logic [DIM_W-1:0] source_height;
  } cfg_t;

  typedef struct packed {
    logic              mode;
    logic              restart;
    logic [7:0]        src_byte;
    logic [7:0]        mask_byte;
    logic [ADDR_W-1:0] word_addr;
  } item_t;

  typedef struct packed {
    logic       en;
    logic       restart;
    logic [7:0] src_byte;
    logic [7:0] mask_byte;
  } load_req_t;

endpackage

>>> rtl/crip_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crip_in_if
// Input channel: load or read words with valid/ready handshake.
// ----------------------------------------------------------------------------
interface crip_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic       restart;
  logic [7:0] src_byte;
  logic [7:0] mask_byte;
  logic [6:0] word_addr;

  modport source (output valid, mode, restart, src_byte, mask_byte, word_addr,
                  input ready);
  modport sink   (input valid, mode, restart, src_byte, mask_byte, word_addr,
                  output ready);
endinterface

>>> rtl/crip_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crip_out_if
// Result channel: one cursor RAM word per handshake.
// ----------------------------------------------------------------------------
interface crip_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] ram_word;

  modport source (output valid, ram_word, input ready);
  modport sink   (input valid, ram_word, output ready);
endinterface

>>> rtl/crip_planes.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crip_planes
// Mask and source planes with the load position counter.
// ----------------------------------------------------------------------------
module crip_planes (
  input  logic               clk,
  input  logic               rst_n,
  input  crip_pkg::cfg_t     cfg,
  input  crip_pkg::load_req_t ld,
  output crip_pkg::plane_t   mask_plane,
  output crip_pkg::plane_t   src_plane
);

  crip_pkg::plane_t                mask_r, mask_nxt;
  crip_pkg::plane_t                src_r, src_nxt;
  logic [crip_pkg::DIM_W-1:0]      row_r, row_nxt;
  logic [crip_pkg::COL_W-1:0]      col_r, col_nxt;

  logic [crip_pkg::DIM_W-1:0]      w_sat;
  logic [crip_pkg::DIM_W-1:0]      w_sum;
  logic [5:0]                      stride_words;
  logic [crip_pkg::COL_W-1:0]      stride;
  logic [crip_pkg::DIM_W-1:0]      eff_row;
  logic [crip_pkg::COL_W-1:0]      eff_col;
  logic [crip_pkg::COL_W-1:0]      col_inc;
  crip_pkg::plane_t                mask_base, src_base;
  logic                            store;
  logic [7:0]                      src_masked;

  // Stride in bytes is the width rounded up to whole 32-bit words.
  always_comb begin
    w_sat        = (cfg.source_width > crip_pkg::WIDTH_MAX) ? crip_pkg::WIDTH_MAX
                                                            : cfg.source_width;
    w_sum        = w_sat + 11'd31;
    stride_words = w_sum[crip_pkg::DIM_W-1:5];
    stride       = {stride_words, 2'b00};
  end

  always_comb begin
    eff_row    = ld.restart ? '0 : row_r;
    eff_col    = ld.restart ? '0 : col_r;
    mask_base  = ld.restart ? '0 : mask_r;
    src_base   = ld.restart ? '0 : src_r;
    col_inc    = eff_col + 8'd1;
    src_masked = ld.src_byte & ld.mask_byte;
    store      = (eff_row < cfg.source_height)
               && (eff_row < crip_pkg::DIM_W'(crip_pkg::CURSOR_SIZE))
               && (eff_col < crip_pkg::COL_W'(crip_pkg::CURSOR_SIZE / 8));

    mask_nxt = mask_r;
    src_nxt  = src_r;
    row_nxt  = row_r;
    col_nxt  = col_r;
    if (ld.en) begin
      mask_nxt = mask_base;
      src_nxt  = src_base;
      row_nxt  = eff_row;
      col_nxt  = eff_col;
      // A zero stride leaves everything as the restart left it.
      if (stride != '0) begin
        if (store) begin
          mask_nxt[eff_row[crip_pkg::ROW_W-1:0]][eff_col[1:0]*8 +: 8] = ld.mask_byte;
          src_nxt[eff_row[crip_pkg::ROW_W-1:0]][eff_col[1:0]*8 +: 8]  = src_masked;
        end
        if (col_inc >= stride) begin
          col_nxt = '0;
          if (eff_row < crip_pkg::ROW_SAT) begin
            row_nxt = eff_row + 11'd1;
          end
        end else begin
          col_nxt = col_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '0;
      src_r  <= '0;
      row_r  <= '0;
      col_r  <= '0;
    end else begin
      mask_r <= mask_nxt;
      src_r  <= src_nxt;
      row_r  <= row_nxt;
      col_r  <= col_nxt;
    end
  end

  assign mask_plane = mask_r;
  assign src_plane  = src_r;

`ifndef SYNTHESIS
  // The column never runs past the largest stride of 128 bytes.
  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    col_r <= 8'd127)
    else $error("load column out of range");
`endif

endmodule

>>> rtl/crip_word.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crip_word
// Composes one 8-byte cursor RAM word from the planes, with rotation.
// ----------------------------------------------------------------------------
module crip_word (
  input  crip_pkg::cfg_t                 cfg,
  input  crip_pkg::plane_t               mask_plane,
  input  crip_pkg::plane_t               src_plane,
  input  logic [crip_pkg::ADDR_W-1:0]    word_addr,
  output logic [crip_pkg::WORD_W-1:0]    ram_word
);

  logic                          rot_cw, rot_ccw, rotated;
  logic [crip_pkg::ROW_W-1:0]    dr;
  logic                          half;
  logic [crip_pkg::CURSOR_SIZE-1:0] m_row, s_row;
  logic [crip_pkg::CURSOR_SIZE-1:0] m_col_cw, s_col_cw, m_col_ccw, s_col_ccw;
  logic [15:0]                   m_pix, s_pix;
  logic [crip_pkg::ROW_W-1:0]    dc;
  logic [7:0]                    m0, s0, m1, s1;

  always_comb begin
    rot_cw  = (cfg.rotation == crip_pkg::ROT_CW);
    rot_ccw = (cfg.rotation == crip_pkg::ROT_CCW);
    rotated = rot_cw || rot_ccw;
    dr      = word_addr[crip_pkg::ROW_W:1];
    half    = word_addr[0];
    m_row   = mask_plane[dr];
    s_row   = src_plane[dr];

    // Rotated views take one column of every stored row.
    for (int y = 0; y < crip_pkg::CURSOR_SIZE; y++) begin
      m_col_cw[y]  = mask_plane[y][dr];
      s_col_cw[y]  = src_plane[y][dr];
      m_col_ccw[y] = mask_plane[y][~dr];
      s_col_ccw[y] = src_plane[y][~dr];
    end

    dc = '0;
    for (int k = 0; k < 16; k++) begin
      dc = {half, 4'(k)};
      if (rot_cw) begin
        m_pix[k] = m_col_cw[~dc];
        s_pix[k] = s_col_cw[~dc];
      end else if (rot_ccw) begin
        m_pix[k] = m_col_ccw[dc];
        s_pix[k] = s_col_ccw[dc];
      end else begin
        m_pix[k] = m_row[dc];
        s_pix[k] = s_row[dc];
      end
    end

    // Displayed bytes carry the leftmost pixel in the MSB.
    for (int j = 0; j < 8; j++) begin
      m0[7-j] = m_pix[j];
      s0[7-j] = s_pix[j];
      m1[7-j] = m_pix[8+j];
      s1[7-j] = s_pix[8+j];
    end

    if (word_addr[crip_pkg::ADDR_W-1]) begin
      ram_word = rotated ? 64'h0000_0000_00FF_00FF : '0;
    end else begin
      ram_word = {32'h0, s1, ~m1, s0, ~m0};
    end
  end

endmodule

>>> rtl/cursor_image_rotate_pack.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cursor_image_rotate_pack
// Packs a monochrome cursor into a 32x32 two-plane cursor RAM image.
//
//  channel | direction | carries
//  --------+-----------+------------------------------------------------
//  in_if   | sink      | mode, restart, src_byte, mask_byte, word_addr
//  out_if  | source    | ram_word (one word per read)
//  cfg_    | write     | rotation, source_width, source_height
//
// Every word passes an input register and, for a read, a result register;
// one word is accepted per cycle while no read is held by a stalled result.
// A load updates the flip-flop planes as it leaves the input register.
// Reset is synchronous; it clears the planes, position and valid flags and loads the default configuration.
// A read waiting on a stalled result register holds the input side.
// ----------------------------------------------------------------------------
module cursor_image_rotate_pack (
  input  logic                             clk,
  input  logic                             rst_n,
  crip_in_if.sink                          in_if,
  crip_out_if.source                       out_if,
  input  logic                             cfg_we,
  input  logic [crip_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [crip_pkg::DIM_W-1:0]       cfg_data
);

  crip_pkg::cfg_t                  cfg_r, cfg_nxt;
  logic                            s1_valid_r, s1_valid_nxt;
  crip_pkg::item_t                 s1_item_r, s1_item_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [crip_pkg::WORD_W-1:0]     out_word_r, out_word_nxt;
  logic                            s1_go;
  logic                            s1_is_read;
  logic                            in_take;
  crip_pkg::load_req_t             ld;
  crip_pkg::plane_t                mask_plane, src_plane;
  logic [crip_pkg::WORD_W-1:0]     rd_word;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        crip_pkg::REG_ROTATION: cfg_nxt.rotation      = cfg_data[1:0];
        crip_pkg::REG_WIDTH:    cfg_nxt.source_width  = cfg_data;
        crip_pkg::REG_HEIGHT:   cfg_nxt.source_height = cfg_data;
        default:                cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    s1_is_read = (s1_item_r.mode == crip_pkg::MODE_READ);
    s1_go      = s1_valid_r && (!s1_is_read || !out_valid_r || out_if.ready);
    in_take    = in_if.valid && in_if.ready;

    s1_valid_nxt = in_take || (s1_valid_r && !s1_go);
    s1_item_nxt  = s1_item_r;
    if (in_take) begin
      s1_item_nxt = '{mode: in_if.mode, restart: in_if.restart,
                      src_byte: in_if.src_byte, mask_byte: in_if.mask_byte,
                      word_addr: in_if.word_addr};
    end

    ld = '{en: s1_go && !s1_is_read, restart: s1_item_r.restart,
           src_byte: s1_item_r.src_byte, mask_byte: s1_item_r.mask_byte};

    out_valid_nxt = out_valid_r && !out_if.ready;
    out_word_nxt  = out_word_r;
    if (s1_go && s1_is_read) begin
      out_valid_nxt = 1'b1;
      out_word_nxt  = rd_word;
    end
  end

  assign in_if.ready     = !s1_valid_r || s1_go;
  assign out_if.valid    = out_valid_r;
  assign out_if.ram_word = out_word_r;

  crip_planes u_planes (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .ld         (ld),
    .mask_plane (mask_plane),
    .src_plane  (src_plane)
  );

  crip_word u_word (
    .cfg        (cfg_r),
    .mask_plane (mask_plane),
    .src_plane  (src_plane),
    .word_addr  (s1_item_r.word_addr),
    .ram_word   (rd_word)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r       <= '{rotation: crip_pkg::ROT_NONE,
                       source_width: crip_pkg::WIDTH_RST,
                       source_height: crip_pkg::HEIGHT_RST};
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cfg_r       <= cfg_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_item_r  <= s1_item_nxt;
    out_word_r <= out_word_nxt;
  end

`ifndef SYNTHESIS
  // A read leaving the input register always lands in the result register.
  a_read_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && s1_is_read) |=> out_valid_r)
    else $error("read word lost");

  // A result only appears after a read has left the input register.
  a_result_from_read: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_go && s1_is_read))
    else $error("result without read");

  // A read held behind a stalled result blocks the input side.
  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_is_read && out_valid_r && !out_if.ready) |-> !in_if.ready)
    else $error("input accepted while read is stalled");
`endif

endmodule
